// File: rtl/sorted_interval_coalescer_defines.svh
// Assertion macros shared by the coalescer modules.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef SORTED_INTERVAL_COALESCER_DEFINES_SVH
`define SORTED_INTERVAL_COALESCER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SIC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SIC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/sic_pkg.sv
package sic_pkg;

  // Fixed widths of the channel value fields.
  localparam int unsigned SIC_VAL_W = 64;

  // Result queue geometry.
  localparam int unsigned SIC_FIFO_DEPTH = 4;
  localparam int unsigned SIC_PTR_W      = 2;
  localparam int unsigned SIC_CNT_W      = 3;

  // One coalesced span as it leaves the block.
  typedef struct packed {
    logic [SIC_VAL_W-1:0] lower;
    logic [SIC_VAL_W-1:0] upper;
    logic                 lower_closed;
    logic                 upper_closed;
    logic                 end_flag;
  } span_t;

  // Result slots written by one processed item; second is set only with first.
  typedef struct packed {
    logic first;
    logic second;
  } sic_push_t;

endpackage

// File: rtl/sic_if.sv
// Span input channel.
interface sic_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] lower_value;
  logic [63:0] upper_value;
  logic        lower_closed;
  logic        upper_closed;
  logic        final_span;

  modport source (output valid, lower_value, upper_value, lower_closed, upper_closed,
                  final_span, input ready);
  modport sink   (input valid, lower_value, upper_value, lower_closed, upper_closed,
                  final_span, output ready);
endinterface

// Coalesced span result channel.
interface sic_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] out_lower;
  logic [63:0] out_upper;
  logic        out_lower_closed;
  logic        out_upper_closed;
  logic        out_end;

  modport source (output valid, out_lower, out_upper, out_lower_closed, out_upper_closed,
                  out_end, input ready);
  modport sink   (input valid, out_lower, out_upper, out_lower_closed, out_upper_closed,
                  out_end, output ready);
endinterface

// File: rtl/sic_merge.sv
module sic_merge #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  logic                   run_valid,
  input  logic [VALUE_WIDTH-1:0] run_lo,
  input  logic [VALUE_WIDTH-1:0] run_up,
  input  logic                   run_loc,
  input  logic                   run_upc,
  input  logic [VALUE_WIDTH-1:0] new_lo,
  input  logic [VALUE_WIDTH-1:0] new_up,
  input  logic                   new_loc,
  input  logic                   new_upc,
  input  logic                   new_fin,
  output logic                   nxt_valid,
  output logic [VALUE_WIDTH-1:0] nxt_lo,
  output logic [VALUE_WIDTH-1:0] nxt_up,
  output logic                   nxt_loc,
  output logic                   nxt_upc,
  output sic_pkg::sic_push_t     push,
  output sic_pkg::span_t         slot0,
  output sic_pkg::span_t         slot1
);
  import sic_pkg::*;

  logic touch_lo;
  logic touch_up;
  logic do_merge;
  logic lo_less;
  logic lo_eq;
  logic up_more;
  logic up_eq;
  logic emit_old;
  logic [VALUE_WIDTH-1:0] mrg_lo;
  logic [VALUE_WIDTH-1:0] mrg_up;
  logic mrg_loc;
  logic mrg_upc;
  span_t old_beat;
  span_t fin_beat;

  // The running upper must reach the new lower, and the new upper the running lower.
  assign touch_lo = ($signed(new_lo) < $signed(run_up)) ||
                    ((new_lo == run_up) && (run_upc || new_loc));
  assign touch_up = ($signed(run_lo) < $signed(new_up)) ||
                    ((run_lo == new_up) && (new_upc || run_loc));
  assign do_merge = run_valid && touch_lo && touch_up;
  assign emit_old = run_valid && !do_merge;

  // Outer bounds win; on equal values an inclusive bound wins.
  assign lo_less = $signed(new_lo) < $signed(run_lo);
  assign lo_eq   = new_lo == run_lo;
  assign up_more = $signed(run_up) < $signed(new_up);
  assign up_eq   = new_up == run_up;

  always_comb begin
    mrg_lo  = run_lo;
    mrg_loc = run_loc;
    if (lo_less) begin
      mrg_lo  = new_lo;
      mrg_loc = new_loc;
    end else if (lo_eq) begin
      mrg_loc = run_loc || new_loc;
    end
    mrg_up  = run_up;
    mrg_upc = run_upc;
    if (up_more) begin
      mrg_up  = new_up;
      mrg_upc = new_upc;
    end else if (up_eq) begin
      mrg_upc = run_upc || new_upc;
    end
  end

  // Next running span: merged, or replaced by the new span.
  assign nxt_lo    = do_merge ? mrg_lo  : new_lo;
  assign nxt_up    = do_merge ? mrg_up  : new_up;
  assign nxt_loc   = do_merge ? mrg_loc : new_loc;
  assign nxt_upc   = do_merge ? mrg_upc : new_upc;
  assign nxt_valid = !new_fin;

  // Beats for the displaced running span and for the flush at a final span.
  assign old_beat.lower        = SIC_VAL_W'($signed(run_lo));
  assign old_beat.upper        = SIC_VAL_W'($signed(run_up));
  assign old_beat.lower_closed = run_loc;
  assign old_beat.upper_closed = run_upc;
  assign old_beat.end_flag     = 1'b0;

  assign fin_beat.lower        = SIC_VAL_W'($signed(nxt_lo));
  assign fin_beat.upper        = SIC_VAL_W'($signed(nxt_up));
  assign fin_beat.lower_closed = nxt_loc;
  assign fin_beat.upper_closed = nxt_upc;
  assign fin_beat.end_flag     = 1'b1;

  // Old span goes first; the flush follows it or stands alone.
  assign push.first  = emit_old || new_fin;
  assign push.second = emit_old && new_fin;
  assign slot0       = emit_old ? old_beat : fin_beat;
  assign slot1       = fin_beat;

endmodule

// File: rtl/sic_out_fifo.sv
`include "sorted_interval_coalescer_defines.svh"

module sic_out_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  sic_pkg::sic_push_t push,
  input  sic_pkg::span_t     slot0,
  input  sic_pkg::span_t     slot1,
  output logic               room,
  sic_out_if.source          out_s
);
  import sic_pkg::*;

  span_t                buf_r [SIC_FIFO_DEPTH];
  logic [SIC_PTR_W-1:0] wr_ptr_r;
  logic [SIC_PTR_W-1:0] wr_ptr_nxt;
  logic [SIC_PTR_W-1:0] rd_ptr_r;
  logic [SIC_PTR_W-1:0] rd_ptr_nxt;
  logic [SIC_CNT_W-1:0] cnt_r;
  logic [SIC_CNT_W-1:0] cnt_nxt;
  logic                 pop;
  logic [SIC_CNT_W-1:0] n_push;
  span_t                head;

  // Two free entries are needed for the worst case of one item.
  assign room = cnt_r <= SIC_CNT_W'(SIC_FIFO_DEPTH - 2);
  assign pop  = out_s.valid && out_s.ready;

  assign n_push     = SIC_CNT_W'(push.first) + SIC_CNT_W'(push.second);
  assign wr_ptr_nxt = wr_ptr_r + SIC_PTR_W'(n_push);
  assign rd_ptr_nxt = rd_ptr_r + SIC_PTR_W'(pop);
  assign cnt_nxt    = cnt_r + n_push - SIC_CNT_W'(pop);

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage: up to two contiguous entries written per cycle.
  always_ff @(posedge clk) begin
    if (push.first) begin
      buf_r[wr_ptr_r] <= slot0;
    end
    if (push.second) begin
      buf_r[wr_ptr_r + SIC_PTR_W'(1)] <= slot1;
    end
  end

  // Head of the queue drives the result channel.
  assign head                   = buf_r[rd_ptr_r];
  assign out_s.valid            = cnt_r != '0;
  assign out_s.out_lower        = head.lower;
  assign out_s.out_upper        = head.upper;
  assign out_s.out_lower_closed = head.lower_closed;
  assign out_s.out_upper_closed = head.upper_closed;
  assign out_s.out_end          = head.end_flag;

  `SIC_ASSERT_NOW(a_no_overflow, push.first, cnt_r <= SIC_CNT_W'(SIC_FIFO_DEPTH - 2), "result queue written without room")
  `SIC_ASSERT_NOW(a_second_needs_first, push.second, push.first, "second slot written alone")
  `SIC_ASSERT_NEXT(a_cnt_track, 1'b1, cnt_r == $past(cnt_nxt) && cnt_r <= SIC_CNT_W'(SIC_FIFO_DEPTH), "queue fill count out of range")

endmodule

// File: rtl/sorted_interval_coalescer.sv
// Sorted interval coalescer.
// in_s carries spans sorted by lower bound, one beat per span, with inclusive
// flags for each bound and final_span on the last span of an array. out_s
// carries coalesced spans; out_end marks the last one of an array.
// Both channels use valid/ready; a beat moves when both are high.
// Only the low VALUE_WIDTH bits of each value are used; results are
// sign-extended back to 64 bits.
// A span is registered at the input, merged against the running span once the
// result buffer has room, and its results go into the buffer that drives out_s.
// Throughput: one span per cycle. The merge is a set of signed compares and
// multiplexers; results queue in a four-entry buffer, and the input stalls only
// when that buffer holds more than two beats.
// A span produces no beat, one beat, or two beats (the displaced running span
// and then the final flush).
// Reset (synchronous, active low) drops the running span, empties the result
// buffer and the input register. When the receiver stalls, results collect
// in the buffer and in_s.ready drops once it cannot take two more beats.
`include "sorted_interval_coalescer_defines.svh"

module sorted_interval_coalescer #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input logic       clk,
  input logic       rst_n,
  sic_in_if.sink    in_s,
  sic_out_if.source out_s
);
  import sic_pkg::*;

  // Input register.
  logic                   stg_valid_r;
  logic [VALUE_WIDTH-1:0] stg_lo_r;
  logic [VALUE_WIDTH-1:0] stg_up_r;
  logic                   stg_loc_r;
  logic                   stg_upc_r;
  logic                   stg_fin_r;

  // Running span.
  logic                   run_valid_r;
  logic [VALUE_WIDTH-1:0] run_lo_r;
  logic [VALUE_WIDTH-1:0] run_up_r;
  logic                   run_loc_r;
  logic                   run_upc_r;

  logic                   run_valid_nxt;
  logic [VALUE_WIDTH-1:0] run_lo_nxt;
  logic [VALUE_WIDTH-1:0] run_up_nxt;
  logic                   run_loc_nxt;
  logic                   run_upc_nxt;

  logic      in_fire;
  logic      adv;
  logic      room;
  sic_push_t mrg_push;
  sic_push_t push;
  span_t     slot0;
  span_t     slot1;

  // The staged span is processed once the buffer can take its results.
  assign adv        = stg_valid_r && room;
  assign in_s.ready = !stg_valid_r || adv;
  assign in_fire    = in_s.valid && in_s.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (in_fire) begin
      stg_valid_r <= 1'b1;
    end else if (adv) begin
      stg_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      stg_lo_r  <= in_s.lower_value[VALUE_WIDTH-1:0];
      stg_up_r  <= in_s.upper_value[VALUE_WIDTH-1:0];
      stg_loc_r <= in_s.lower_closed;
      stg_upc_r <= in_s.upper_closed;
      stg_fin_r <= in_s.final_span;
    end
  end

  // Merge the staged span into the running span.
  sic_merge #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_merge (
    .run_valid (run_valid_r),
    .run_lo    (run_lo_r),
    .run_up    (run_up_r),
    .run_loc   (run_loc_r),
    .run_upc   (run_upc_r),
    .new_lo    (stg_lo_r),
    .new_up    (stg_up_r),
    .new_loc   (stg_loc_r),
    .new_upc   (stg_upc_r),
    .new_fin   (stg_fin_r),
    .nxt_valid (run_valid_nxt),
    .nxt_lo    (run_lo_nxt),
    .nxt_up    (run_up_nxt),
    .nxt_loc   (run_loc_nxt),
    .nxt_upc   (run_upc_nxt),
    .push      (mrg_push),
    .slot0     (slot0),
    .slot1     (slot1)
  );

  // Running span updates only when the staged span is processed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_valid_r <= 1'b0;
    end else if (adv) begin
      run_valid_r <= run_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      run_lo_r  <= run_lo_nxt;
      run_up_r  <= run_up_nxt;
      run_loc_r <= run_loc_nxt;
      run_upc_r <= run_upc_nxt;
    end
  end

  // Result buffer.
  assign push.first  = adv && mrg_push.first;
  assign push.second = adv && mrg_push.second;

  sic_out_fifo u_out_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .slot0 (slot0),
    .slot1 (slot1),
    .room  (room),
    .out_s (out_s)
  );

  `SIC_ASSERT_NEXT(a_final_clears_run, adv && stg_fin_r, !run_valid_r, "running span kept after final span")
  `SIC_ASSERT_NOW(a_final_pushes, adv && stg_fin_r, push.first, "final span produced no result")
  `SIC_ASSERT_NOW(a_no_old_without_run, adv && !run_valid_r, !push.second && (push.first == stg_fin_r), "result emitted with no running span")

endmodule

// File: tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sic_pkg::*;

  localparam int unsigned VW           = 64;
  localparam int unsigned RANDOM_ITEMS = 1200;
  localparam logic [63:0] S64_MIN      = 64'h8000_0000_0000_0000;
  localparam logic [63:0] S64_MAX      = 64'h7fff_ffff_ffff_ffff;

  // One span as it enters the block.
  typedef struct {
    logic [63:0] lower;
    logic [63:0] upper;
    logic        lower_closed;
    logic        upper_closed;
    logic        final_span;
  } span_beat_t;

  // A row of the directed table; typed rows carry their result written out.
  typedef struct {
    span_beat_t beat;
    bit         typed;
    span_t      want;
  } stim_row_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always #5 clk = ~clk;

  sic_in_if  in_if ();
  sic_out_if out_if ();

  sorted_interval_coalescer #(
    .VALUE_WIDTH(VW)
  ) DUT (
    .clk  (clk),
    .rst_n(rst_n),
    .in_s (in_if),
    .out_s(out_if)
  );

  // Running span kept by the predictor.
  logic [63:0] held_lower;
  logic [63:0] held_upper;
  logic        held_lower_closed;
  logic        held_upper_closed;
  bit          held_valid = 1'b0;

  span_t       expected_spans[$];
  span_t       step_spans[$];
  stim_row_t   directed_rows[$];

  bit          idle_en = 1'b1;
  bit          in_took = 1'b0;
  bit          cur_typed = 1'b0;
  span_t       cur_want;
  span_t       got_want;
  span_beat_t  seen_beat;
  int unsigned errors = 0;
  int unsigned stall_left = 0;

  // Keep the low VW bits of a value and sign-extend them.
  function automatic logic [63:0] sext_value(input logic [63:0] v);
    logic signed [63:0] t;
    t = v << (64 - VW);
    return t >>> (64 - VW);
  endfunction

  // An upper bound touches a lower bound when it lies above it, or on it with
  // at least one side inclusive.
  function automatic bit bound_touches(input logic [63:0] up, input logic upc,
                                       input logic [63:0] lo, input logic loc);
    return ($signed(lo) < $signed(up)) || (lo == up && (upc || loc));
  endfunction

  function automatic span_t make_span(input logic [63:0] lo, input logic [63:0] up,
                                      input logic loc, input logic upc, input logic last);
    span_t s;
    s.lower        = lo;
    s.upper        = up;
    s.lower_closed = loc;
    s.upper_closed = upc;
    s.end_flag     = last;
    return s;
  endfunction

  // Merge one span into the running span and collect the spans it releases.
  function automatic void coalesce_span(input span_beat_t b);
    logic [63:0] lo;
    logic [63:0] up;
    lo = sext_value(b.lower);
    up = sext_value(b.upper);
    step_spans = {};
    if (held_valid && bound_touches(held_upper, held_upper_closed, lo, b.lower_closed) &&
        bound_touches(up, b.upper_closed, held_lower, held_lower_closed)) begin
      if ($signed(lo) < $signed(held_lower)) begin
        held_lower        = lo;
        held_lower_closed = b.lower_closed;
      end else if (lo == held_lower) begin
        held_lower_closed = held_lower_closed || b.lower_closed;
      end
      if ($signed(held_upper) < $signed(up)) begin
        held_upper        = up;
        held_upper_closed = b.upper_closed;
      end else if (up == held_upper) begin
        held_upper_closed = held_upper_closed || b.upper_closed;
      end
    end else begin
      if (held_valid) begin
        step_spans.push_back(make_span(held_lower, held_upper, held_lower_closed,
                                       held_upper_closed, 1'b0));
      end
      held_lower        = lo;
      held_upper        = up;
      held_lower_closed = b.lower_closed;
      held_upper_closed = b.upper_closed;
      held_valid        = 1'b1;
    end
    if (b.final_span) begin
      step_spans.push_back(make_span(held_lower, held_upper, held_lower_closed,
                                     held_upper_closed, 1'b1));
      held_valid = 1'b0;
    end
  endfunction

  // A typed row is a lone final span after a flush, so it comes back as it went in.
  function automatic void add_row(input logic [63:0] lo, input logic [63:0] up,
                                  input logic loc, input logic upc, input logic fin,
                                  input bit typed);
    stim_row_t r;
    r.beat.lower        = lo;
    r.beat.upper        = up;
    r.beat.lower_closed = loc;
    r.beat.upper_closed = upc;
    r.beat.final_span   = fin;
    r.typed             = typed;
    r.want              = make_span(sext_value(lo), sext_value(up), loc, upc, 1'b1);
    directed_rows.push_back(r);
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // Drive one beat at the falling edge, then hold it until it is taken.
  task automatic send_beat(input span_beat_t b, input bit typed, input span_t want);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_if.valid = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_if.valid        = 1'b1;
    in_if.lower_value  = b.lower;
    in_if.upper_value  = b.upper;
    in_if.lower_closed = b.lower_closed;
    in_if.upper_closed = b.upper_closed;
    in_if.final_span   = b.final_span;
    cur_typed          = typed;
    cur_want           = want;
    @(negedge clk);
    while (!in_took) @(negedge clk);
  endtask

  // Receiver side: stall in random bursts while idling is enabled.
  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_if.ready = 1'b0;
      stall_left--;
    end else if (idle_en && $urandom_range(0, 9) == 0) begin
      out_if.ready = 1'b0;
      stall_left   = $urandom_range(0, 16);
    end else begin
      out_if.ready = 1'b1;
    end
  end

  // Predict on every accepted span and check every accepted result beat.
  always @(posedge clk) begin
    in_took = rst_n && in_if.valid && in_if.ready;
    if (in_took) begin
      seen_beat.lower        = in_if.lower_value;
      seen_beat.upper        = in_if.upper_value;
      seen_beat.lower_closed = in_if.lower_closed;
      seen_beat.upper_closed = in_if.upper_closed;
      seen_beat.final_span   = in_if.final_span;
      coalesce_span(seen_beat);
      if (cur_typed) begin
        expected_spans.push_back(cur_want);
      end else begin
        foreach (step_spans[i]) expected_spans.push_back(step_spans[i]);
      end
    end
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_spans.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %h %h %b %b %b", $time,
                 out_if.out_lower, out_if.out_upper, out_if.out_lower_closed,
                 out_if.out_upper_closed, out_if.out_end);
      end else begin
        got_want = expected_spans.pop_front();
        check_field("out_lower", got_want.lower, out_if.out_lower);
        check_field("out_upper", got_want.upper, out_if.out_upper);
        check_field("out_lower_closed", 64'(got_want.lower_closed),
                    64'(out_if.out_lower_closed));
        check_field("out_upper_closed", 64'(got_want.upper_closed),
                    64'(out_if.out_upper_closed));
        check_field("out_end", 64'(got_want.end_flag), 64'(out_if.out_end));
      end
    end
  end

  // Hard limit on the run.
  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    span_beat_t  b;
    span_t       none;
    logic [63:0] base;
    int unsigned sent;
    int unsigned len;

    none               = '0;
    in_if.valid        = 1'b0;
    in_if.lower_value  = '0;
    in_if.upper_value  = '0;
    in_if.lower_closed = 1'b0;
    in_if.upper_closed = 1'b0;
    in_if.final_span   = 1'b0;
    out_if.ready       = 1'b0;

    // Lone final spans: extremes, an empty span and a reversed span.
    add_row(-64'sd5, 64'd10, 1'b1, 1'b1, 1'b1, 1'b1);
    add_row(S64_MIN, S64_MAX, 1'b0, 1'b0, 1'b1, 1'b1);
    add_row(S64_MAX, S64_MAX, 1'b1, 1'b1, 1'b1, 1'b1);
    add_row(S64_MIN, S64_MIN, 1'b0, 1'b0, 1'b1, 1'b1);
    add_row(64'd100, -64'sd100, 1'b1, 1'b0, 1'b1, 1'b1);
    // Overlap, touch on an inclusive bound, a gap on open bounds, a final merge.
    add_row(64'd0, 64'd10, 1'b1, 1'b1, 1'b0, 1'b0);
    add_row(64'd5, 64'd20, 1'b0, 1'b1, 1'b0, 1'b0);
    add_row(64'd20, 64'd30, 1'b0, 1'b0, 1'b0, 1'b0);
    add_row(64'd30, 64'd40, 1'b0, 1'b1, 1'b0, 1'b0);
    add_row(64'd40, 64'd50, 1'b1, 1'b0, 1'b1, 1'b0);
    // A final span that cannot merge releases two results.
    add_row(64'd0, 64'd10, 1'b1, 1'b0, 1'b0, 1'b0);
    add_row(64'd10, 64'd20, 1'b0, 1'b1, 1'b1, 1'b0);
    // Equal bounds: inclusiveness wins the tie.
    add_row(64'd0, 64'd10, 1'b0, 1'b0, 1'b0, 1'b0);
    add_row(64'd0, 64'd10, 1'b1, 1'b1, 1'b1, 1'b0);
    // Unsorted input, once disjoint and once overlapping.
    add_row(64'd50, 64'd60, 1'b1, 1'b1, 1'b0, 1'b0);
    add_row(64'd0, 64'd5, 1'b1, 1'b1, 1'b1, 1'b0);
    add_row(64'd50, 64'd60, 1'b0, 1'b0, 1'b0, 1'b0);
    add_row(64'd40, 64'd55, 1'b1, 1'b0, 1'b1, 1'b0);
    // Across zero, then up to the largest value.
    add_row(-64'sd1, 64'd0, 1'b0, 1'b0, 1'b0, 1'b0);
    add_row(64'd0, 64'd1, 1'b1, 1'b1, 1'b0, 1'b0);
    add_row(S64_MAX - 64'd1, S64_MAX, 1'b1, 1'b0, 1'b0, 1'b0);
    add_row(S64_MAX, S64_MAX, 1'b1, 1'b1, 1'b1, 1'b0);

    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      send_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].want);
    end

    // Random part: mostly sorted arrays with random content, some noise.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      idle_en = !((sent >= 400 && sent < 600) || sent >= 1000);
      if ($urandom_range(0, 7) == 0) begin
        b.lower        = {$urandom, $urandom};
        b.upper        = {$urandom, $urandom};
        b.lower_closed = 1'($urandom_range(0, 1));
        b.upper_closed = 1'($urandom_range(0, 1));
        b.final_span   = ($urandom_range(0, 3) == 0);
        send_beat(b, 1'b0, none);
        sent++;
      end else begin
        len = $urandom_range(1, 8);
        case ($urandom_range(0, 3))
          0: base = {$urandom, $urandom};
          1: base = S64_MIN + 64'($urandom_range(0, 20));
          2: base = S64_MAX - 64'($urandom_range(0, 60));
          default: begin
            base = 64'($urandom_range(0, 400));
            base = base - 64'd200;
          end
        endcase
        for (int unsigned k = 0; k < len; k++) begin
          base    = base + 64'($urandom_range(0, 4));
          b.lower = base;
          b.upper = base + 64'($urandom_range(0, 6));
          // Now and then a reversed span or a step back out of order.
          case ($urandom_range(0, 11))
            0: begin
              b.upper = b.lower;
              b.lower = b.lower + 64'($urandom_range(1, 5));
            end
            1: b.lower = b.lower - 64'($urandom_range(1, 12));
            default: ;
          endcase
          b.lower_closed = 1'($urandom_range(0, 1));
          b.upper_closed = 1'($urandom_range(0, 1));
          b.final_span   = (k == len - 1);
          send_beat(b, 1'b0, none);
          sent++;
        end
      end
    end

    // Close the last array so the running span is flushed.
    b.lower        = 64'd7;
    b.upper        = 64'd9;
    b.lower_closed = 1'b1;
    b.upper_closed = 1'b0;
    b.final_span   = 1'b1;
    send_beat(b, 1'b0, none);

    in_if.valid = 1'b0;
    while (expected_spans.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/sic_pkg.sv
rtl/sic_if.sv
rtl/sic_merge.sv
rtl/sic_out_fifo.sv
rtl/sorted_interval_coalescer.sv
tb/tb_top.sv
